[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks on clk, switched off while rst is high.

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition at one edge implies the consequence at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pgs_pkg.sv]
package pgs_pkg;

  // Bring-up and ranging phases, code values match phase_now
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_POWER_WAIT = 4'd1,
    PH_POWERED    = 4'd2,
    PH_FRESH      = 4'd3,
    PH_TUNED      = 4'd4,
    PH_CONFIGURED = 4'd5,
    PH_INIT       = 4'd6,
    PH_RANGING    = 4'd7,
    PH_NEAR       = 4'd8
  } phase_t;

  // Bus sequence issued in a tick
  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_TUNE        = 3'd1,
    ACT_CONFIGURE   = 3'd2,
    ACT_CLEAR_FRESH = 3'd3,
    ACT_START       = 3'd4,
    ACT_CLEAR_INT   = 3'd5
  } bus_action_t;

  // Configuration register indexes
  localparam int RegIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  typedef enum logic [RegIndexWidth-1:0] {
    REG_NEAR_THRESHOLD = 3'd0,
    REG_CLICK_TIMEOUT  = 3'd1,
    REG_RESET_WAIT     = 3'd2,
    REG_CHECK_PERIOD   = 3'd3,
    REG_POLARITY       = 3'd4
  } reg_index_t;

  // Register reset values
  localparam logic [7:0]  NearThresholdReset = 8'd255;
  localparam logic [15:0] ClickTimeoutReset  = 16'd500;
  localparam logic [15:0] ResetWaitReset     = 16'd1200;
  localparam logic [15:0] CheckPeriodReset   = 16'd1000;
  localparam logic        PolarityReset      = 1'b1;

  // Dim map: (d-10)*255/245 == floor(x*DimRecip >> DimShift) for x in 0..245
  localparam logic [7:0]  DimLow   = 8'd10;
  localparam logic [16:0] DimRecip = 17'd68211;
  localparam int          DimShift = 16;

  typedef struct packed {
    logic [7:0]  near_limit;
    logic [15:0] click_timeout_ms;
    logic [15:0] reset_wait_ms;
    logic [15:0] reset_check_period;
    logic        indicator_polarity;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        fresh_out_of_reset;
    logic        device_ready;
    logic        near_interrupt;
    logic [3:0]  range_error;
    logic [7:0]  distance;
  } tick_t;

  typedef struct packed {
    bus_action_t bus_action;
    logic        sensor_enable;
    logic        indicator_level;
    logic        switch_event;
    logic        switch_on;
    logic        dim_event;
    logic [7:0]  dim_level;
    phase_t      phase_now;
  } result_t;

  // Clamp to 10..255 and scale to 0..255 with one constant multiply
  function automatic logic [7:0] dim_map(input logic [7:0] d);
    logic [7:0]  x;
    logic [24:0] prod;
    x    = (d < DimLow) ? 8'd0 : (d - DimLow);
    prod = 25'(x) * 25'(DimRecip);
    return prod[DimShift +: 8];
  endfunction

endpackage

[rtl/pgs_if.sv]
// Tick channel: one sampled service tick per item
interface pgs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        fresh_out_of_reset;
  logic        device_ready;
  logic        near_interrupt;
  logic [3:0]  range_error;
  logic [7:0]  distance;

  modport source (
    output valid, now_ms, fresh_out_of_reset, device_ready, near_interrupt,
           range_error, distance,
    input  ready
  );
  modport sink (
    input  valid, now_ms, fresh_out_of_reset, device_ready, near_interrupt,
           range_error, distance,
    output ready
  );
endinterface

// Result channel: one result item per tick
interface pgs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic       sensor_enable;
  logic       indicator_level;
  logic       switch_event;
  logic       switch_on;
  logic       dim_event;
  logic [7:0] dim_level;
  logic [3:0] phase_now;

  modport source (
    output valid, bus_action, sensor_enable, indicator_level, switch_event,
           switch_on, dim_event, dim_level, phase_now,
    input  ready
  );
  modport sink (
    input  valid, bus_action, sensor_enable, indicator_level, switch_event,
           switch_on, dim_event, dim_level, phase_now,
    output ready
  );
endinterface

[rtl/pgs_cfg_regs.sv]
module pgs_cfg_regs
  import pgs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [RegIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output cfg_t                     cfg
);

  // Register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_limit         <= NearThresholdReset;
      cfg.click_timeout_ms   <= ClickTimeoutReset;
      cfg.reset_wait_ms      <= ResetWaitReset;
      cfg.reset_check_period <= CheckPeriodReset;
      cfg.indicator_polarity <= PolarityReset;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_NEAR_THRESHOLD: cfg.near_limit         <= cfg_data[7:0];
        REG_CLICK_TIMEOUT:  cfg.click_timeout_ms   <= cfg_data;
        REG_RESET_WAIT:     cfg.reset_wait_ms      <= cfg_data;
        REG_CHECK_PERIOD:   cfg.reset_check_period <= cfg_data;
        REG_POLARITY:       cfg.indicator_polarity <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/pgs_in_stage.sv]
module pgs_in_stage
  import pgs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  tick_valid,
  input  tick_t tick_data,
  output logic  tick_ready,
  input  logic  take,
  output logic  valid,
  output tick_t data
);

  // Refill whenever empty or the held item moves on this cycle
  assign tick_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (tick_ready) begin
      valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_ready && tick_valid) begin
      data <= tick_data;
    end
  end

endmodule

[rtl/pgs_core.sv]
`include "assert_macros.svh"

module pgs_core
  import pgs_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  tick_t   t,
  output logic    take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  typedef logic [TIME_BITS-1:0] stamp_t;

  // Step state
  phase_t      phase, phase_next;
  stamp_t      powered_at, powered_at_next;
  stamp_t      near_since, near_since_next;
  logic [15:0] check_counter, check_counter_next;
  logic        is_on, is_on_next;
  logic        sensor_enabled, sensor_enabled_next;
  logic        indicator_active, indicator_active_next;

  // Per-tick working values
  stamp_t      now_t;
  stamp_t      since_power;
  stamp_t      since_near;
  logic [15:0] period;
  logic [15:0] count_inc;
  logic        near_reading;
  logic        held_long;
  bus_action_t action;
  logic        sw_event;
  logic        dim_event;
  logic        hot_plug;

  // Step when an item is held and the result slot is free or draining
  assign take = in_valid && (!out_valid || out_ready);

  assign now_t        = stamp_t'(t.now_ms);
  assign since_power  = now_t - powered_at;
  assign since_near   = now_t - near_since;
  assign period       = (cfg.reset_check_period == 16'd0) ? 16'd1 : cfg.reset_check_period;
  assign count_inc    = check_counter + 16'd1;
  assign near_reading = (t.range_error == 4'd0) && (t.distance <= cfg.near_limit);
  assign held_long    = since_near >= stamp_t'(cfg.click_timeout_ms);

  // Phase sequencer and gesture tracking
  always_comb begin
    phase_next            = phase;
    powered_at_next       = powered_at;
    near_since_next       = near_since;
    check_counter_next    = check_counter;
    is_on_next            = is_on;
    sensor_enabled_next   = sensor_enabled;
    indicator_active_next = indicator_active;
    action                = ACT_NONE;
    sw_event              = 1'b0;
    dim_event             = 1'b0;
    hot_plug              = 1'b0;
    case (phase)
      PH_IDLE: begin
        sensor_enabled_next = 1'b1;
        powered_at_next     = now_t;
        phase_next          = PH_POWER_WAIT;
      end
      PH_POWER_WAIT: begin
        if (since_power > stamp_t'(cfg.reset_wait_ms)) phase_next = PH_POWERED;
      end
      PH_POWERED: begin
        if (t.fresh_out_of_reset) phase_next = PH_FRESH;
      end
      PH_FRESH: begin
        action     = ACT_TUNE;
        phase_next = PH_TUNED;
      end
      PH_TUNED: begin
        if (t.device_ready) begin
          action     = ACT_CONFIGURE;
          phase_next = PH_CONFIGURED;
        end
      end
      PH_CONFIGURED: begin
        action     = ACT_CLEAR_FRESH;
        phase_next = PH_INIT;
      end
      PH_INIT: begin
        action     = ACT_START;
        phase_next = PH_RANGING;
      end
      PH_RANGING, PH_NEAR: begin
        // periodic hot-plug check on every Nth ranging tick
        check_counter_next = count_inc;
        if (count_inc >= period) begin
          check_counter_next = 16'd0;
          hot_plug           = t.fresh_out_of_reset;
        end
        if (hot_plug) begin
          phase_next          = PH_IDLE;
          sensor_enabled_next = 1'b0;
        end else if (t.near_interrupt) begin
          action = ACT_CLEAR_INT;
          if (phase == PH_RANGING) begin
            phase_next            = PH_NEAR;
            indicator_active_next = 1'b1;
            near_since_next       = now_t;
          end
        end else if (near_reading) begin
          // hold turns the switch on; dim level on every near reading
          if (held_long && !is_on) begin
            is_on_next = 1'b1;
            sw_event   = 1'b1;
          end
          dim_event = 1'b1;
        end else if (phase == PH_NEAR) begin
          // left the near zone: a short pass is a click
          indicator_active_next = 1'b0;
          phase_next            = PH_RANGING;
          if (!held_long) begin
            is_on_next = !is_on;
            sw_event   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      powered_at       <= '0;
      near_since       <= '0;
      check_counter    <= '0;
      is_on            <= 1'b0;
      sensor_enabled   <= 1'b0;
      indicator_active <= 1'b0;
    end else if (take) begin
      phase            <= phase_next;
      powered_at       <= powered_at_next;
      near_since       <= near_since_next;
      check_counter    <= check_counter_next;
      is_on            <= is_on_next;
      sensor_enabled   <= sensor_enabled_next;
      indicator_active <= indicator_active_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.bus_action      <= action;
      res.sensor_enable   <= sensor_enabled_next;
      res.indicator_level <= ~(indicator_active_next ^ cfg.indicator_polarity);
      res.switch_event    <= sw_event;
      res.switch_on       <= is_on_next;
      res.dim_event       <= dim_event;
      res.dim_level       <= dim_event ? dim_map(t.distance) : 8'd0;
      res.phase_now       <= phase_next;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_sensor_follows_phase, !out_valid || (res.sensor_enable == (res.phase_now != PH_IDLE)), "sensor enable disagrees with phase")
  `ASSERT_ALWAYS(a_switch_only_ranging, !(out_valid && res.switch_event) || res.phase_now == PH_RANGING || res.phase_now == PH_NEAR, "switch event outside ranging")
  `ASSERT_ALWAYS(a_dim_quiet_bus, !(out_valid && res.dim_event) || res.bus_action == ACT_NONE, "dim event with bus action")
  `ASSERT_NEXT(a_phase_holds_idle, !take, $stable(phase), "phase moved without a step")

endmodule

[rtl/proximity_gesture_switch.sv]
// Proximity gesture switch and dimmer. Each tick item carries the time and the sensor flags
// sampled for one service tick; each tick yields exactly one result item naming the bus
// sequence to issue, the pin levels, switch and dim reports and the phase reached. One item is
// accepted every clock cycle unless the result channel stalls: the whole step is a single pass
// of logic between the input register and the result register; while a result waits, one more
// item can still enter the input register before the tick channel stalls. Registers must be
// written through cfg_we/cfg_index/cfg_data only while no item is in flight; the block itself
// does not enforce this. TIME_BITS sets the width of the stored timestamps; time differences
// wrap modulo 2^TIME_BITS.
module proximity_gesture_switch
  import pgs_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  pgs_in_if.sink                   tick,
  pgs_out_if.source                result,
  input  logic                     cfg_we,
  input  logic [RegIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t    cfg;
  tick_t   tick_data;
  tick_t   held;
  logic    held_valid;
  logic    take;
  result_t res;

  // Gather the tick payload
  assign tick_data.now_ms             = tick.now_ms;
  assign tick_data.fresh_out_of_reset = tick.fresh_out_of_reset;
  assign tick_data.device_ready       = tick.device_ready;
  assign tick_data.near_interrupt     = tick.near_interrupt;
  assign tick_data.range_error        = tick.range_error;
  assign tick_data.distance           = tick.distance;

  pgs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pgs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_data  (tick_data),
    .tick_ready (tick.ready),
    .take       (take),
    .valid      (held_valid),
    .data       (held)
  );

  pgs_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (held_valid),
    .t         (held),
    .take      (take),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res       (res)
  );

  // Spread the result onto the channel
  assign result.bus_action      = res.bus_action;
  assign result.sensor_enable   = res.sensor_enable;
  assign result.indicator_level = res.indicator_level;
  assign result.switch_event    = res.switch_event;
  assign result.switch_on       = res.switch_on;
  assign result.dim_event       = res.dim_event;
  assign result.dim_level       = res.dim_level;
  assign result.phase_now       = res.phase_now;

endmodule
